[src/asc_pkg.sv]
`default_nettype none
package asc_pkg;

  localparam int SLOTS         = 6;
  localparam int CAPTURE_DEPTH = 64;

  localparam int SLOT_W     = 3;
  localparam int CH_W       = 4;
  localparam int SMP_W      = 10;
  localparam int TIME_W     = 32;
  localparam int HOLD_W     = 6;
  localparam int CIDX_W     = 6;
  localparam int BYTE_W     = 8;
  localparam int ORDER_W    = 24;
  localparam int CNT_W      = $clog2(CAPTURE_DEPTH > 1 ? CAPTURE_DEPTH : 2);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 24'h543210;
  localparam logic [CH_W-1:0]    CAPCH_RESET = 4'd2;
  localparam logic [BYTE_W-1:0]  BYTE_SAT    = 8'hFF;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(CAPTURE_DEPTH - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_ORDER   = 2'd0,
    CFG_CAPTURE_CHANNEL = 2'd1
  } cfg_idx_e;

  // One classified conversion, front to back.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [SMP_W-1:0]  sample;
    logic [TIME_W-1:0] now_us;
    logic              fill_request;
    logic              slot_hold;
    logic              capture_hold;
    logic              cycle_hold;
    logic              cap_match;
    logic              wrap;
    logic [CH_W-1:0]   next_channel;
  } asc_cmd_t;

endpackage
`default_nettype wire

[src/asc_if.sv]
`default_nettype none
interface asc_in_if;
  import asc_pkg::*;
  logic              valid;
  logic              ready;
  logic [SMP_W-1:0]  sample;
  logic [TIME_W-1:0] now_us;
  logic              fill_request;
  logic [HOLD_W-1:0] result_hold_mask;
  logic              capture_hold;
  logic              cycle_hold;

  modport source (output valid, sample, now_us, fill_request, result_hold_mask,
                  capture_hold, cycle_hold, input ready);
  modport sink   (input valid, sample, now_us, fill_request, result_hold_mask,
                  capture_hold, cycle_hold, output ready);
endinterface

interface asc_out_if;
  import asc_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic [SMP_W-1:0]  slot_value;
  logic              slot_on;
  logic              capture_write;
  logic [CIDX_W-1:0] capture_index;
  logic [BYTE_W-1:0] capture_byte;
  logic              capture_done;
  logic [TIME_W-1:0] capture_start_time;
  logic [TIME_W-1:0] capture_end_time;
  logic [TIME_W-1:0] scan_start_time;
  logic [TIME_W-1:0] scan_end_time;
  logic [CH_W-1:0]   next_channel;

  modport source (output valid, slot, slot_value, slot_on, capture_write, capture_index,
                  capture_byte, capture_done, capture_start_time, capture_end_time,
                  scan_start_time, scan_end_time, next_channel, input ready);
  modport sink   (input valid, slot, slot_value, slot_on, capture_write, capture_index,
                  capture_byte, capture_done, capture_start_time, capture_end_time,
                  scan_start_time, scan_end_time, next_channel, output ready);
endinterface
`default_nettype wire

[src/asc_front.sv]
`default_nettype none
module asc_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  asc_in_if.sink                         smp_i,
  input  wire logic [asc_pkg::ORDER_W-1:0] channel_order_i,
  input  wire logic [asc_pkg::CH_W-1:0]  capture_channel_i,
  output asc_pkg::asc_cmd_t              cmd_o,
  output logic                           cmd_valid_o,
  input  wire logic                      cmd_ready_i
);
  import asc_pkg::*;

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              wrap;

  assign wrap   = (slot_q >= LAST_SLOT);
  assign slot_d = wrap ? '0 : slot_q + 1'b1;

  assign cmd_valid_o = smp_i.valid;
  assign smp_i.ready = cmd_ready_i;

  always_comb begin
    cmd_o              = '0;
    cmd_o.slot         = slot_q;
    cmd_o.sample       = smp_i.sample;
    cmd_o.now_us       = smp_i.now_us;
    cmd_o.fill_request = smp_i.fill_request;
    cmd_o.slot_hold    = smp_i.result_hold_mask[slot_q];
    cmd_o.capture_hold = smp_i.capture_hold;
    cmd_o.cycle_hold   = smp_i.cycle_hold;
    cmd_o.cap_match    = (channel_order_i[slot_q*CH_W +: CH_W] == capture_channel_i);
    cmd_o.wrap         = wrap;
    cmd_o.next_channel = channel_order_i[slot_d*CH_W +: CH_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (smp_i.valid && cmd_ready_i) begin
      slot_q <= slot_d;
    end
  end

endmodule
`default_nettype wire

[src/asc_queue.sv]
`default_nettype none
module asc_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire asc_pkg::asc_cmd_t push_data_i,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  output asc_pkg::asc_cmd_t      pop_data_o,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i
);
  import asc_pkg::*;

  asc_cmd_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[src/asc_back.sv]
`default_nettype none
module asc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire asc_pkg::asc_cmd_t cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  asc_out_if.source              res_o
);
  import asc_pkg::*;

  logic [SMP_W-1:0]  stored_q [SLOTS];
  logic [CNT_W-1:0]  count_q, count_d;
  logic              armed_q, armed_d;
  logic              filled_q, filled_d;
  logic [TIME_W-1:0] cap_start_raw_q, cap_start_raw_d;
  logic [TIME_W-1:0] cap_start_held_q, cap_start_held_d;
  logic [TIME_W-1:0] cap_end_held_q, cap_end_held_d;
  logic [TIME_W-1:0] scan_end_raw_q, scan_end_raw_d;
  logic [TIME_W-1:0] scan_start_held_q, scan_start_held_d;
  logic [TIME_W-1:0] scan_end_held_q, scan_end_held_d;

  logic              out_valid_q;
  logic              take;
  logic              wr;
  logic [BYTE_W-1:0] wbyte;
  logic [SMP_W-1:0]  slot_value;

  assign cmd_ready_o = !out_valid_q || res_o.ready;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign res_o.valid = out_valid_q;

  assign slot_value = cmd_i.slot_hold ? stored_q[cmd_i.slot] : cmd_i.sample;
  assign wbyte      = (cmd_i.sample[SMP_W-1:BYTE_W] != '0) ? BYTE_SAT
                                                           : cmd_i.sample[BYTE_W-1:0];

  always_comb begin
    armed_d           = armed_q | cmd_i.fill_request;
    filled_d          = filled_q & ~cmd_i.fill_request;
    count_d           = count_q;
    cap_start_raw_d   = cap_start_raw_q;
    cap_start_held_d  = cap_start_held_q;
    cap_end_held_d    = cap_end_held_q;
    scan_end_raw_d    = scan_end_raw_q;
    scan_start_held_d = scan_start_held_q;
    scan_end_held_d   = scan_end_held_q;
    wr                = 1'b0;

    if (cmd_i.cap_match) begin
      if (armed_d && !filled_d) begin
        wr = 1'b1;
        if (count_q == '0) cap_start_raw_d = cmd_i.now_us;
        if (count_q >= LAST_CNT) begin
          count_d  = '0;
          armed_d  = 1'b0;
          filled_d = 1'b1;
          if (!cmd_i.capture_hold) begin
            cap_start_held_d = cap_start_raw_d;
            cap_end_held_d   = cmd_i.now_us;
          end
        end else begin
          count_d = count_q + 1'b1;
        end
      end else begin
        count_d = '0;
      end
    end

    // full scan done: last end time becomes the new start unless cycle_hold
    if (cmd_i.wrap) begin
      scan_end_raw_d = cmd_i.now_us;
      if (!cmd_i.cycle_hold) begin
        scan_start_held_d = scan_end_raw_q;
        scan_end_held_d   = cmd_i.now_us;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) stored_q[i] <= '0;
      count_q           <= '0;
      armed_q           <= 1'b0;
      filled_q          <= 1'b0;
      cap_start_raw_q   <= '0;
      cap_start_held_q  <= '0;
      cap_end_held_q    <= '0;
      scan_end_raw_q    <= '0;
      scan_start_held_q <= '0;
      scan_end_held_q   <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      if (take) begin
        if (!cmd_i.slot_hold) stored_q[cmd_i.slot] <= cmd_i.sample;
        count_q           <= count_d;
        armed_q           <= armed_d;
        filled_q          <= filled_d;
        cap_start_raw_q   <= cap_start_raw_d;
        cap_start_held_q  <= cap_start_held_d;
        cap_end_held_q    <= cap_end_held_d;
        scan_end_raw_q    <= scan_end_raw_d;
        scan_start_held_q <= scan_start_held_d;
        scan_end_held_q   <= scan_end_held_d;
        out_valid_q       <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_o.slot               <= cmd_i.slot;
      res_o.slot_value         <= slot_value;
      res_o.slot_on            <= (cmd_i.sample[SMP_W-1:BYTE_W] != '0);
      res_o.capture_write      <= wr;
      res_o.capture_index      <= wr ? CIDX_W'(count_q) : '0;
      res_o.capture_byte       <= wr ? wbyte : '0;
      res_o.capture_done       <= filled_d;
      res_o.capture_start_time <= cap_start_held_d;
      res_o.capture_end_time   <= cap_end_held_d;
      res_o.scan_start_time    <= scan_start_held_d;
      res_o.scan_end_time      <= scan_end_held_d;
      res_o.next_channel       <= cmd_i.next_channel;
    end
  end

endmodule
`default_nettype wire

[src/adc_scan_sequencer_with_capture_unit.sv]
`default_nettype none
// Round-robin ADC scan sequencer with a one-shot capture buffer. Each input
// transaction is one finished conversion of the current slot plus its time
// stamp; each one yields exactly one result transaction carrying the slot,
// its stored value, the on flag, the capture buffer write (index and
// saturated byte), the capture done flag, the held capture and scan times
// and the mux channel to convert next. Throughput is one transaction per
// clock while the result side is ready. The accepting edge writes the
// two-entry command queue, and the result register is loaded when the back
// end takes the command from the queue. The rate is set by the back end,
// which updates its state each time it takes a command. The front end owns
// the slot counter and classifies each conversion against the channel
// order; the back end owns the stored values, capture and scan state.
// Configuration (index 0 channel order, index 1 capture channel) is to be
// written only while no transaction is in flight; other indexes are
// ignored.
module adc_scan_sequencer_with_capture_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [asc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [asc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  asc_in_if.sink                              smp_i,
  asc_out_if.source                           res_o
);
  import asc_pkg::*;

  logic [ORDER_W-1:0] channel_order_q;
  logic [CH_W-1:0]    capture_channel_q;

  asc_cmd_t front_cmd, back_cmd;
  logic     front_valid, front_ready;
  logic     back_valid, back_ready;

  // config registers, values masked to their widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_order_q   <= ORDER_RESET;
      capture_channel_q <= CAPCH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANNEL_ORDER:   channel_order_q   <= cfg_data_i[ORDER_W-1:0];
        CFG_CAPTURE_CHANNEL: capture_channel_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  asc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .smp_i             (smp_i),
    .channel_order_i   (channel_order_q),
    .capture_channel_i (capture_channel_q),
    .cmd_o             (front_cmd),
    .cmd_valid_o       (front_valid),
    .cmd_ready_i       (front_ready)
  );

  asc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  asc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire
